// File: sv/seq_pkg.sv
// Package for the sorted event queue: operation and status codes, cell command
// type and default sizes. No dependencies.
`default_nettype none

package seq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int TAG_WIDTH_DEF = 16;

  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_INSERT    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_NEAR = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_FAR  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP       = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    C_HOLD,
    C_INS,
    C_PUSH_FAR,
    C_POP
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       use_hit;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: sv/seq_cell.sv
// One storage cell of the queue chain: holds a key/tag pair and a suffix-OR hit bit.
// Depends on seq_pkg.
`default_nettype none

module seq_cell #(
  parameter int KEY_WIDTH = 32,
  parameter int TAG_WIDTH = 16,
  parameter int CNT_W     = 5,
  parameter int IDX       = 0
) (
  input  wire                    clk,
  input  seq_pkg::cell_cmd_t     cmd,
  input  wire  [CNT_W-1:0]       fill,
  input  wire  [KEY_WIDTH-1:0]   new_key,
  input  wire  [TAG_WIDTH-1:0]   new_tag,
  input  wire  [KEY_WIDTH-1:0]   below_key,
  input  wire  [TAG_WIDTH-1:0]   below_tag,
  input  wire                    below_hit,
  input  wire  [KEY_WIDTH-1:0]   above_key,
  input  wire  [TAG_WIDTH-1:0]   above_tag,
  input  wire                    above_hit,
  output logic [KEY_WIDTH-1:0]   key_o,
  output logic [TAG_WIDTH-1:0]   tag_o,
  output logic                   hit_o
);
  import seq_pkg::*;

  localparam logic [CNT_W-1:0] POS = CNT_W'(IDX);

  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [TAG_WIDTH-1:0] tag_r, tag_nxt;
  logic                 hit_r, hit_nxt;
  logic                 own_hit, low_hit;

  // hit: some occupied cell at or above this one holds key <= new key
  assign hit_nxt = ((POS < fill) && (key_r <= new_key)) || above_hit;
  assign own_hit = cmd.use_hit & hit_r;
  assign low_hit = (IDX == 0) ? 1'b1 : (cmd.use_hit & below_hit);

  always_comb begin
    key_nxt = key_r;
    tag_nxt = tag_r;
    case (cmd.mode)
      C_INS: begin
        if (!own_hit) begin
          if (low_hit) begin
            key_nxt = new_key;
            tag_nxt = new_tag;
          end else begin
            key_nxt = below_key;
            tag_nxt = below_tag;
          end
        end
      end
      C_PUSH_FAR: begin
        if (POS == fill) begin
          key_nxt = new_key;
          tag_nxt = new_tag;
        end
      end
      C_POP: begin
        key_nxt = above_key;
        tag_nxt = above_tag;
      end
      default: begin
        key_nxt = key_r;
        tag_nxt = tag_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    tag_r <= tag_nxt;
    hit_r <= hit_nxt;
  end

  assign key_o = key_r;
  assign tag_o = tag_r;
  assign hit_o = hit_r;

endmodule

`default_nettype wire

// File: sv/sorted_event_queue_top.sv
// Sorted event queue top: control sequencer over a chain of seq_cell instances.
// Push, pop, clear and rejected ops: result registered in the cycle after accept,
// one per cycle while the output is not stalled. Sorted insert: the hit bit ripples
// down the cell chain in S_SCAN, then S_APPLY waits for a free output and registers
// the result; no new op is taken until the insert completes. Cell 0 is the pop end.
// Synchronous active-low reset empties the queue; no sweep. Depends on seq_pkg and seq_cell.
`default_nettype none

module sorted_event_queue_top #(
  parameter int DEPTH     = seq_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = seq_pkg::KEY_WIDTH_DEF,
  parameter int TAG_WIDTH = seq_pkg::TAG_WIDTH_DEF,
  localparam int CW       = $clog2(DEPTH + 1),
  localparam int IN_TW    = ((KEY_WIDTH + TAG_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW   = ((KEY_WIDTH + TAG_WIDTH + seq_pkg::STATUS_W + CW + 7) / 8) * 8
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [IN_TW-1:0]             in_tdata,   // key, tag
  input  wire  [seq_pkg::FUNC_W-1:0]   in_tuser,   // func
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [OUT_TW-1:0]            out_tdata   // out_key, out_tag, status, entry_count
);
  import seq_pkg::*;

  localparam int SC_W = $clog2(DEPTH);
  localparam logic [CW-1:0]   FULL_CNT  = CW'(DEPTH);
  localparam logic [SC_W-1:0] SCAN_LAST = SC_W'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_t;

  state_t                state_r, state_nxt;
  logic [SC_W-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]         fill_r, fill_nxt;
  logic [KEY_WIDTH-1:0]  key_r, key_nxt;
  logic [TAG_WIDTH-1:0]  tag_r, tag_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [KEY_WIDTH-1:0]  out_key_r, out_key_nxt;
  logic [TAG_WIDTH-1:0]  out_tag_r, out_tag_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [CW-1:0]         out_count_r, out_count_nxt;

  logic [KEY_WIDTH-1:0]  in_key;
  logic [TAG_WIDTH-1:0]  in_tag;
  logic                  accept, out_free, is_full, is_empty;
  logic [KEY_WIDTH-1:0]  new_key;
  logic [TAG_WIDTH-1:0]  new_tag;
  cell_cmd_t             cmd;

  logic [KEY_WIDTH-1:0]  cell_key [DEPTH];
  logic [TAG_WIDTH-1:0]  cell_tag [DEPTH];
  logic                  cell_hit [DEPTH];
  logic [KEY_WIDTH-1:0]  bel_key  [DEPTH];
  logic [TAG_WIDTH-1:0]  bel_tag  [DEPTH];
  logic                  bel_hit  [DEPTH];
  logic [KEY_WIDTH-1:0]  abv_key  [DEPTH];
  logic [TAG_WIDTH-1:0]  abv_tag  [DEPTH];
  logic                  abv_hit  [DEPTH];

  assign in_key   = in_tdata[KEY_WIDTH-1:0];
  assign in_tag   = in_tdata[KEY_WIDTH +: TAG_WIDTH];
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept   = in_tvalid && in_tready;
  assign is_full  = (fill_r == FULL_CNT);
  assign is_empty = (fill_r == '0);
  assign new_key  = (state_r == S_IDLE) ? in_key : key_r;
  assign new_tag  = (state_r == S_IDLE) ? in_tag : tag_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    fill_nxt       = fill_r;
    key_nxt        = key_r;
    tag_nxt        = tag_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_key_nxt    = out_key_r;
    out_tag_nxt    = out_tag_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    cmd.mode       = C_HOLD;
    cmd.use_hit    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt  = 1'b1;
          out_key_nxt    = '0;
          out_tag_nxt    = '0;
          out_status_nxt = ST_OK;
          case (in_tuser)
            FUNC_INSERT: begin
              if (is_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                out_valid_nxt = 1'b0;
                key_nxt       = in_key;
                tag_nxt       = in_tag;
                cnt_nxt       = '0;
                state_nxt     = S_SCAN;
              end
            end
            FUNC_PUSH_NEAR: begin
              if (is_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                cmd.mode = C_INS;
                fill_nxt = fill_r + 1'b1;
              end
            end
            FUNC_PUSH_FAR: begin
              if (is_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                cmd.mode = C_PUSH_FAR;
                fill_nxt = fill_r + 1'b1;
              end
            end
            FUNC_POP: begin
              if (is_empty) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                cmd.mode    = C_POP;
                fill_nxt    = fill_r - 1'b1;
                out_key_nxt = cell_key[0];
                out_tag_nxt = cell_tag[0];
              end
            end
            FUNC_CLEAR: begin
              fill_nxt = '0;
            end
            default: begin
              fill_nxt = fill_r;
            end
          endcase
          out_count_nxt = fill_nxt;
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SCAN_LAST) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (out_free) begin
          cmd.mode       = C_INS;
          cmd.use_hit    = 1'b1;
          fill_nxt       = fill_r + 1'b1;
          out_valid_nxt  = 1'b1;
          out_key_nxt    = '0;
          out_tag_nxt    = '0;
          out_status_nxt = ST_OK;
          out_count_nxt  = fill_r + 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    key_r        <= key_nxt;
    tag_r        <= tag_nxt;
    out_key_r    <= out_key_nxt;
    out_tag_r    <= out_tag_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  generate
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign bel_key[gi] = '0;
        assign bel_tag[gi] = '0;
        assign bel_hit[gi] = 1'b1;
      end else begin : g_mid
        assign bel_key[gi] = cell_key[gi-1];
        assign bel_tag[gi] = cell_tag[gi-1];
        assign bel_hit[gi] = cell_hit[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign abv_key[gi] = '0;
        assign abv_tag[gi] = '0;
        assign abv_hit[gi] = 1'b0;
      end else begin : g_up
        assign abv_key[gi] = cell_key[gi+1];
        assign abv_tag[gi] = cell_tag[gi+1];
        assign abv_hit[gi] = cell_hit[gi+1];
      end

      seq_cell #(
        .KEY_WIDTH (KEY_WIDTH),
        .TAG_WIDTH (TAG_WIDTH),
        .CNT_W     (CW),
        .IDX       (gi)
      ) u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .fill      (fill_r),
        .new_key   (new_key),
        .new_tag   (new_tag),
        .below_key (bel_key[gi]),
        .below_tag (bel_tag[gi]),
        .below_hit (bel_hit[gi]),
        .above_key (abv_key[gi]),
        .above_tag (abv_tag[gi]),
        .above_hit (abv_hit[gi]),
        .key_o     (cell_key[gi]),
        .tag_o     (cell_tag[gi]),
        .hit_o     (cell_hit[gi])
      );
    end
  endgenerate

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TW'({out_count_r, out_status_r, out_tag_r, out_key_r});

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("fill level above depth");

  a_insert_scans: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_tuser == FUNC_INSERT) && !is_full |=> (state_r == S_SCAN) && !out_valid_r)
    else $error("sorted insert did not start a scan");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_tuser == FUNC_POP) && !is_empty |=> fill_r == CW'($past(fill_r) - 1'b1))
    else $error("pop did not decrement fill level");

  a_apply_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) && out_free |=> out_valid_r && (out_count_r == fill_r))
    else $error("insert result count mismatch");

endmodule

`default_nettype wire
